FILE: sv/assert_macros.svh
// Assertion macros for the checker file of the governor block.
// Depends on nothing; included by lbg_checker, the file that holds the assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication into the next cycle, disabled while reset is low.
`define LBG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Condition that must hold at every clock edge outside reset.
`define LBG_ASSERT_NOW(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`endif

FILE: sv/lbg_pkg.sv
// Types, widths and constants of the load budget governor.
// Depends on nothing; imported by every module of the block and referenced by its interfaces.
package lbg_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned BUD_W   = 24;
    localparam int unsigned LOAD_W  = 23;
    localparam int unsigned FRAC_W  = 16;
    localparam int unsigned GUARD_W = LOAD_W - FRAC_W;
    localparam int unsigned TGT_W   = 17;
    localparam int unsigned RATE_W  = 16;
    localparam int unsigned WARM_W  = 16;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned IDX_W   = 8;
    localparam int unsigned DATA_W  = 24;

    localparam int unsigned MUL_A_W = 24;
    localparam int unsigned MUL_B_W = 17;
    localparam int unsigned PROD_W  = MUL_A_W + MUL_B_W;
    localparam int unsigned QUO_W   = 25;
    localparam int unsigned FEED_W  = 25;
    localparam int unsigned STEP_W  = 5;

    localparam logic [STEP_W-1:0]  LOAD_STEPS = STEP_W'(LOAD_W);
    localparam logic [STEP_W-1:0]  AFF_STEPS  = STEP_W'(QUO_W);
    localparam logic [LOAD_W-1:0]  LOAD_LIMIT = 23'd4194304;
    localparam logic [LOAD_W-1:0]  LOAD_ONE   = 23'd65536;
    localparam logic [MUL_B_W-1:0] ONE_Q16    = 17'd65536;
    localparam logic [PROD_W-1:0]  ROUND_HALF = 41'd32768;

    localparam logic [BUD_W-1:0]  CEILING_DEFAULT = 24'd4194304;
    localparam logic [TGT_W-1:0]  TARGET_MIN  = 17'd3277;
    localparam logic [TGT_W-1:0]  TARGET_MAX  = 17'd65536;
    localparam logic [RATE_W-1:0] ATTACK_MIN  = 16'd66;
    localparam logic [RATE_W-1:0] ATTACK_MAX  = 16'd58982;
    localparam logic [RATE_W-1:0] RELEASE_MAX = 16'd58982;
    localparam logic [TGT_W-1:0]  BAND_MIN    = 17'd6554;
    localparam logic [TGT_W-1:0]  BAND_MAX    = 17'd65536;

    typedef enum logic [IDX_W-1:0] {
        CFG_CEILING = 8'd0,
        CFG_FLOOR   = 8'd1,
        CFG_TARGET  = 8'd2,
        CFG_ATTACK  = 8'd3,
        CFG_RELEASE = 8'd4,
        CFG_BAND    = 8'd5,
        CFG_WARMUP  = 8'd6,
        CFG_LOOP    = 8'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [BUD_W-1:0]  ceiling_units;
        logic [BUD_W-1:0]  floor_units;
        logic [TGT_W-1:0]  target_load;
        logic [RATE_W-1:0] attack_rate;
        logic [RATE_W-1:0] release_rate;
        logic [TGT_W-1:0]  dead_band;
        logic [WARM_W-1:0] warmup_blocks;
        logic              loop_enabled;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        ceiling_units: 24'd4194304,
        floor_units:   24'd0,
        target_load:   17'd49152,
        attack_rate:   16'd6554,
        release_rate:  16'd655,
        dead_band:     17'd52429,
        warmup_blocks: 16'd16,
        loop_enabled:  1'b1
    };

    typedef enum logic [1:0] {
        ALU_NOP,
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        logic busy;
        logic done;
    } t_alu_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD_DIV,
        ST_LOAD_CHK,
        ST_SMOOTH,
        ST_PEAK,
        ST_ATTACK,
        ST_AFF_MUL,
        ST_AFF_DIV,
        ST_BAND,
        ST_RELEASE,
        ST_DONE
    } t_state;

endpackage

FILE: sv/lbg_if.sv
// Handshake interfaces of the governor: input items, results and register writes.
// Depends on lbg_pkg for the field widths.
interface lbg_item_if;
    logic                          valid;
    logic                          ready;
    logic [lbg_pkg::TIME_W-1:0]    elapsed_ticks;
    logic [lbg_pkg::TIME_W-1:0]    deadline_ticks;
    logic [lbg_pkg::BUD_W-1:0]     units_spent;

    modport source (output valid, output elapsed_ticks, output deadline_ticks,
                    output units_spent, input ready);
    modport sink   (input valid, input elapsed_ticks, input deadline_ticks,
                    input units_spent, output ready);
endinterface

interface lbg_result_if;
    logic                          valid;
    logic                          ready;
    logic [lbg_pkg::BUD_W-1:0]     budget_units;
    logic [lbg_pkg::LOAD_W-1:0]    smoothed_load_out;
    logic [lbg_pkg::LOAD_W-1:0]    peak_load_out;
    logic [lbg_pkg::CNT_W-1:0]     pressure_count;
    logic                          sample_accepted;

    modport source (output valid, output budget_units, output smoothed_load_out,
                    output peak_load_out, output pressure_count,
                    output sample_accepted, input ready);
    modport sink   (input valid, input budget_units, input smoothed_load_out,
                    input peak_load_out, input pressure_count,
                    input sample_accepted, output ready);
endinterface

interface lbg_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [lbg_pkg::IDX_W-1:0]     index;
    logic [lbg_pkg::DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/lbg_cfg.sv
// Configuration register file of the governor, with clamping after each write.
// Depends on lbg_pkg and the lbg_cfg_if interface.
module lbg_cfg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lbg_cfg_if.sink       i_cfg,
    output lbg_pkg::t_cfg o_cfg,
    output logic          o_clamp
);
    import lbg_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;
    t_cfg w_cfg;
    logic w_known;
    logic w_write;
    logic r_clamp;

    assign i_cfg.ready = 1'b1;
    assign w_write     = i_cfg.valid && i_cfg.ready && w_known;

    always_comb begin
        w_cfg   = r_cfg;
        w_known = 1'b1;
        case (i_cfg.index)
            CFG_CEILING: w_cfg.ceiling_units = i_cfg.data[BUD_W-1:0];
            CFG_FLOOR:   w_cfg.floor_units   = i_cfg.data[BUD_W-1:0];
            CFG_TARGET:  w_cfg.target_load   = i_cfg.data[TGT_W-1:0];
            CFG_ATTACK:  w_cfg.attack_rate   = i_cfg.data[RATE_W-1:0];
            CFG_RELEASE: w_cfg.release_rate  = i_cfg.data[RATE_W-1:0];
            CFG_BAND:    w_cfg.dead_band     = i_cfg.data[TGT_W-1:0];
            CFG_WARMUP:  w_cfg.warmup_blocks = i_cfg.data[WARM_W-1:0];
            CFG_LOOP:    w_cfg.loop_enabled  = i_cfg.data[0];
            default:     w_known = 1'b0;
        endcase

        n_cfg = w_cfg;
        if (n_cfg.ceiling_units == '0) begin
            n_cfg.ceiling_units = CEILING_DEFAULT;
        end
        if (n_cfg.floor_units > n_cfg.ceiling_units) begin
            n_cfg.floor_units = n_cfg.ceiling_units;
        end
        if (n_cfg.target_load < TARGET_MIN) begin
            n_cfg.target_load = TARGET_MIN;
        end else if (n_cfg.target_load > TARGET_MAX) begin
            n_cfg.target_load = TARGET_MAX;
        end
        if (n_cfg.attack_rate < ATTACK_MIN) begin
            n_cfg.attack_rate = ATTACK_MIN;
        end else if (n_cfg.attack_rate > ATTACK_MAX) begin
            n_cfg.attack_rate = ATTACK_MAX;
        end
        if (n_cfg.release_rate > RELEASE_MAX) begin
            n_cfg.release_rate = RELEASE_MAX;
        end
        if (n_cfg.dead_band < BAND_MIN) begin
            n_cfg.dead_band = BAND_MIN;
        end else if (n_cfg.dead_band > BAND_MAX) begin
            n_cfg.dead_band = BAND_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg   <= CFG_RESET;
            r_clamp <= 1'b0;
        end else begin
            r_clamp <= w_write;
            if (w_write) begin
                r_cfg <= n_cfg;
            end
        end
    end

    assign o_cfg   = r_cfg;
    assign o_clamp = r_clamp;

endmodule

FILE: sv/lbg_alu.sv
// Shared arithmetic unit: a registered multiplier and a one-bit-per-cycle divider.
// Depends on lbg_pkg for operand widths, opcodes and the status struct.
module lbg_alu #(
    parameter int unsigned DIV_W = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lbg_pkg::t_alu_op             i_op,
    input  logic [lbg_pkg::MUL_A_W-1:0]  i_mul_a,
    input  logic [lbg_pkg::MUL_B_W-1:0]  i_mul_b,
    input  logic [DIV_W-1:0]             i_div_rem,
    input  logic [DIV_W-1:0]             i_div_den,
    input  logic [lbg_pkg::FEED_W-1:0]   i_div_feed,
    input  logic [lbg_pkg::STEP_W-1:0]   i_div_steps,
    output logic [lbg_pkg::PROD_W-1:0]   o_prod,
    output logic [lbg_pkg::QUO_W-1:0]    o_quo,
    output lbg_pkg::t_alu_status         o_status
);
    import lbg_pkg::*;

    logic [PROD_W-1:0] r_prod;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;
    logic [FEED_W-1:0] r_feed;
    logic [QUO_W-1:0]  r_quo;
    logic [STEP_W-1:0] r_cnt;
    logic              r_done;

    logic [DIV_W:0]    w_trial;
    logic [DIV_W:0]    w_diff;
    logic              w_fit;
    logic              w_step;
    logic              w_start;

    assign w_step  = (r_cnt != '0);
    assign w_start = !w_step && (i_op == ALU_DIV);
    assign w_trial = {r_rem, r_feed[FEED_W-1]};
    assign w_fit   = (w_trial >= {1'b0, r_den});
    assign w_diff  = w_trial - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= w_step && (r_cnt == STEP_W'(1));
            if (w_step) begin
                r_cnt <= r_cnt - STEP_W'(1);
            end else if (w_start) begin
                r_cnt <= i_div_steps;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == ALU_MUL) begin
            r_prod <= PROD_W'(i_mul_a) * PROD_W'(i_mul_b);
        end
        if (w_step) begin
            r_rem  <= w_fit ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
            r_feed <= {r_feed[FEED_W-2:0], 1'b0};
            r_quo  <= {r_quo[QUO_W-2:0], w_fit};
        end else if (w_start) begin
            r_rem  <= i_div_rem;
            r_den  <= i_div_den;
            r_feed <= i_div_feed;
            r_quo  <= '0;
        end
    end

    assign o_prod        = r_prod;
    assign o_quo         = r_quo;
    assign o_status.busy = w_step;
    assign o_status.done = r_done;

endmodule

FILE: sv/load_budget_governor_top.sv
// Top level of the load budget governor: sequencer, metering state and result register.
// Depends on lbg_pkg, the lbg interfaces, lbg_cfg and lbg_alu.
//
//   port       dir   word                                         handshake
//   i_item     in    elapsed_ticks, deadline_ticks, units_spent   valid / ready
//   o_result   out   budget_units, smoothed/peak load, pressure   valid / ready
//   i_cfg      in    index, data                                  valid / ready
//
// An item is metered, has its affordable budget divided out as well when needed, ends
// after the load division when the load exceeds 64.0, or is rejected before the load
// division; the load division takes 23 divider steps, the budget division 25.
// Reset is synchronous and active low and resets the metering state.
// Input is taken only while the sequencer is idle, and an unread result holds the
// next item only at its own end. Register writes are always ready.
module load_budget_governor_top #(
    parameter int unsigned LOAD_SMOOTHING = 6554,
    parameter int unsigned PEAK_DECAY     = 64881,
    parameter int unsigned TIME_BITS      = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lbg_item_if.sink      i_item,
    lbg_result_if.source  o_result,
    lbg_cfg_if.sink       i_cfg
);
    import lbg_pkg::*;

    localparam int unsigned EW = (TIME_BITS < TIME_W) ? TIME_BITS : TIME_W;
    localparam int unsigned DW = (EW > LOAD_W) ? EW : LOAD_W;
    localparam int unsigned CW = EW + GUARD_W;
    localparam logic [MUL_B_W-1:0] SMOOTH_K = MUL_B_W'(LOAD_SMOOTHING);
    localparam logic [MUL_B_W-1:0] DECAY_K  = MUL_B_W'(PEAK_DECAY);

    t_cfg        w_cfg;
    logic        w_clamp;
    t_alu_op     w_op;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [DW-1:0]      w_div_rem;
    logic [DW-1:0]      w_div_den;
    logic [FEED_W-1:0]  w_div_feed;
    logic [STEP_W-1:0]  w_div_steps;
    logic [PROD_W-1:0]  w_prod;
    logic [QUO_W-1:0]   w_quo;
    t_alu_status        w_status;

    t_state r_state;
    t_state n_state;

    logic [EW-1:0]     r_elapsed;
    logic [EW-1:0]     r_deadline;
    logic [BUD_W-1:0]  r_units;
    logic [LOAD_W-1:0] r_load;
    logic              r_ok;
    logic [LOAD_W-1:0] r_sm_new;
    logic [LOAD_W-1:0] r_peak_new;
    logic [BUD_W-1:0]  r_bud_new;
    logic [BUD_W-1:0]  r_next;
    logic              r_warm_dec;

    logic [BUD_W-1:0]  r_budget;
    logic [LOAD_W-1:0] r_smoothed;
    logic [LOAD_W-1:0] r_peak;
    logic [WARM_W-1:0] r_warmup;
    logic [CNT_W-1:0]  r_pressure;

    logic              r_out_valid;
    logic [BUD_W-1:0]  r_out_budget;
    logic [LOAD_W-1:0] r_out_smoothed;
    logic [LOAD_W-1:0] r_out_peak;
    logic [CNT_W-1:0]  r_out_pressure;
    logic              r_out_ok;

    logic              w_accept;
    logic              w_out_free;
    logic              w_finish;
    logic              w_reject_early;
    logic              w_over;
    logic              w_need_aff;
    logic [LOAD_W-1:0] w_diff;
    logic [PROD_W-1:0] w_round;
    logic [LOAD_W-1:0] w_step;
    logic [BUD_W-1:0]  w_cut;
    logic [BUD_W-1:0]  w_pick;
    logic [PROD_W:0]   w_grow;
    logic [PROD_W-FRAC_W:0] w_grow_q;
    logic              w_under;
    logic [CNT_W-1:0]  w_press_new;

    lbg_cfg u_lbg_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg),
        .o_clamp (w_clamp)
    );

    lbg_alu #(
        .DIV_W (DW)
    ) u_lbg_alu (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op        (w_op),
        .i_mul_a     (w_mul_a),
        .i_mul_b     (w_mul_b),
        .i_div_rem   (w_div_rem),
        .i_div_den   (w_div_den),
        .i_div_feed  (w_div_feed),
        .i_div_steps (w_div_steps),
        .o_prod      (w_prod),
        .o_quo       (w_quo),
        .o_status    (w_status)
    );

    assign i_item.ready   = (r_state == ST_IDLE);
    assign w_accept       = i_item.valid && i_item.ready;
    assign w_out_free     = !r_out_valid || o_result.ready;
    assign w_finish       = (r_state == ST_DONE) && w_out_free;

    assign w_reject_early = (r_deadline == '0) ||
                            (CW'(r_elapsed) >= {r_deadline, {GUARD_W{1'b0}}});
    assign w_over         = (r_load > LOAD_W'(w_cfg.target_load));
    assign w_need_aff     = (r_load >= LOAD_ONE) && (r_units != '0);
    assign w_diff         = (r_load >= r_smoothed) ? (r_load - r_smoothed)
                                                   : (r_smoothed - r_load);
    assign w_round        = w_prod + ROUND_HALF;
    assign w_step         = w_round[FRAC_W +: LOAD_W];
    assign w_cut          = w_prod[FRAC_W +: BUD_W];
    assign w_pick         = ({1'b0, r_next} > w_quo) ? w_quo[BUD_W-1:0] : r_next;
    assign w_under        = ({r_load, {FRAC_W{1'b0}}} < (LOAD_W + FRAC_W)'(w_prod));
    assign w_grow         = (PROD_W + 1)'(w_prod)
                          + (PROD_W + 1)'({w_cfg.release_rate, 12'b0});
    assign w_grow_q       = w_grow[PROD_W:FRAC_W];
    assign w_press_new    = (r_ok && w_over && (r_pressure != '1))
                          ? r_pressure + CNT_W'(1) : r_pressure;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        w_op        = ALU_NOP;
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_div_rem   = '0;
        w_div_den   = '0;
        w_div_feed  = '0;
        w_div_steps = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_item.valid) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (w_reject_early) begin
                    n_state = ST_DONE;
                end else begin
                    w_op        = ALU_DIV;
                    w_div_rem   = DW'(r_elapsed >> GUARD_W);
                    w_div_den   = DW'(r_deadline);
                    w_div_feed  = {r_elapsed[GUARD_W-1:0], {(FEED_W - GUARD_W){1'b0}}};
                    w_div_steps = LOAD_STEPS;
                    n_state     = ST_LOAD_DIV;
                end
            end
            ST_LOAD_DIV: begin
                if (w_status.done) begin
                    n_state = ST_LOAD_CHK;
                end
            end
            ST_LOAD_CHK: begin
                if (!r_ok) begin
                    n_state = ST_DONE;
                end else begin
                    w_op    = ALU_MUL;
                    w_mul_a = MUL_A_W'(w_diff);
                    w_mul_b = SMOOTH_K;
                    n_state = ST_SMOOTH;
                end
            end
            ST_SMOOTH: begin
                w_op    = ALU_MUL;
                w_mul_a = MUL_A_W'(r_peak);
                w_mul_b = DECAY_K;
                n_state = ST_PEAK;
            end
            ST_PEAK: begin
                if (!w_cfg.loop_enabled || (r_warmup != '0)) begin
                    n_state = ST_DONE;
                end else if (w_over) begin
                    w_op    = ALU_MUL;
                    w_mul_a = r_budget;
                    w_mul_b = ONE_Q16 - MUL_B_W'(w_cfg.attack_rate);
                    n_state = ST_ATTACK;
                end else begin
                    w_op    = ALU_MUL;
                    w_mul_a = MUL_A_W'(w_cfg.target_load);
                    w_mul_b = w_cfg.dead_band;
                    n_state = ST_BAND;
                end
            end
            ST_ATTACK: begin
                if (w_need_aff) begin
                    w_op    = ALU_MUL;
                    w_mul_a = r_units;
                    w_mul_b = w_cfg.target_load;
                    n_state = ST_AFF_MUL;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_AFF_MUL: begin
                w_op        = ALU_DIV;
                w_div_rem   = DW'(w_prod[PROD_W-1:QUO_W]);
                w_div_den   = DW'(r_load);
                w_div_feed  = w_prod[FEED_W-1:0];
                w_div_steps = AFF_STEPS;
                n_state     = ST_AFF_DIV;
            end
            ST_AFF_DIV: begin
                if (w_status.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_BAND: begin
                if (w_under) begin
                    w_op    = ALU_MUL;
                    w_mul_a = r_budget;
                    w_mul_b = ONE_Q16 + MUL_B_W'(w_cfg.release_rate);
                    n_state = ST_RELEASE;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_RELEASE: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_elapsed  <= i_item.elapsed_ticks[EW-1:0];
            r_deadline <= i_item.deadline_ticks[EW-1:0];
            r_units    <= i_item.units_spent;
        end
        case (r_state)
            ST_LOAD_DIV: begin
                r_load <= w_quo[LOAD_W-1:0];
            end
            ST_SMOOTH: begin
                r_sm_new <= (r_load >= r_smoothed) ? (r_smoothed + w_step)
                                                   : (r_smoothed - w_step);
            end
            ST_PEAK: begin
                r_peak_new <= (r_load > r_peak) ? r_load : w_prod[FRAC_W +: LOAD_W];
                r_bud_new  <= (w_cfg.loop_enabled && (r_warmup != '0))
                            ? w_cfg.ceiling_units : r_budget;
            end
            ST_ATTACK: begin
                r_next <= w_cut;
                if (!w_need_aff) begin
                    r_bud_new <= (w_cut < w_cfg.floor_units) ? w_cfg.floor_units : w_cut;
                end
            end
            ST_AFF_DIV: begin
                r_bud_new <= (w_pick < w_cfg.floor_units) ? w_cfg.floor_units : w_pick;
            end
            ST_RELEASE: begin
                r_bud_new <= (w_grow_q > (PROD_W - FRAC_W + 1)'(w_cfg.ceiling_units))
                           ? w_cfg.ceiling_units : w_grow_q[BUD_W-1:0];
            end
            default: begin
            end
        endcase
        if (w_finish) begin
            r_out_budget   <= r_ok ? r_bud_new : r_budget;
            r_out_smoothed <= r_ok ? r_sm_new : r_smoothed;
            r_out_peak     <= r_ok ? r_peak_new : r_peak;
            r_out_pressure <= w_press_new;
            r_out_ok       <= r_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok        <= 1'b0;
            r_warm_dec  <= 1'b0;
            r_budget    <= CFG_RESET.ceiling_units;
            r_smoothed  <= '0;
            r_peak      <= '0;
            r_warmup    <= CFG_RESET.warmup_blocks;
            r_pressure  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_ok <= 1'b0;
            end else if ((r_state == ST_LOAD_DIV) && w_status.done) begin
                r_ok <= (w_quo <= QUO_W'(LOAD_LIMIT));
            end
            if (r_state == ST_PEAK) begin
                r_warm_dec <= w_cfg.loop_enabled && (r_warmup != '0);
            end else if (w_accept) begin
                r_warm_dec <= 1'b0;
            end

            if (w_finish && r_ok) begin
                r_budget   <= r_bud_new;
                r_smoothed <= r_sm_new;
                r_peak     <= r_peak_new;
                r_pressure <= w_press_new;
                if (r_warm_dec) begin
                    r_warmup <= r_warmup - WARM_W'(1);
                end
            end else if (w_clamp) begin
                if (r_budget < w_cfg.floor_units) begin
                    r_budget <= w_cfg.floor_units;
                end else if (r_budget > w_cfg.ceiling_units) begin
                    r_budget <= w_cfg.ceiling_units;
                end
            end

            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result.valid             = r_out_valid;
    assign o_result.budget_units      = r_out_budget;
    assign o_result.smoothed_load_out = r_out_smoothed;
    assign o_result.peak_load_out     = r_out_peak;
    assign o_result.pressure_count    = r_out_pressure;
    assign o_result.sample_accepted   = r_out_ok;

endmodule

FILE: sv/lbg_checker.sv
// Port-level assertions for the governor top level, attached by a bind statement.
// Depends on lbg_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lbg_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_valid,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [lbg_pkg::BUD_W-1:0]    i_budget,
    input logic [lbg_pkg::LOAD_W-1:0]   i_smoothed,
    input logic [lbg_pkg::LOAD_W-1:0]   i_peak,
    input logic [lbg_pkg::CNT_W-1:0]    i_pressure
);
    import lbg_pkg::*;

    `LBG_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready, "input still ready right after a word was taken")
    `LBG_ASSERT_NOW(a_load_in_range, i_clk, i_rst_n, !i_out_valid || ((i_smoothed <= LOAD_LIMIT) && (i_peak <= LOAD_LIMIT)), "result load beyond the load limit")
    `LBG_ASSERT_NEXT(a_result_held, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "result word dropped before it was taken")
    `LBG_ASSERT_NEXT(a_result_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_budget) && $stable(i_pressure), "stalled result word changed")

endmodule

bind load_budget_governor_top lbg_checker u_lbg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_budget    (o_result.budget_units),
    .i_smoothed  (o_result.smoothed_load_out),
    .i_peak      (o_result.peak_load_out),
    .i_pressure  (o_result.pressure_count)
);

FILE: test/load_budget_governor_top_tb.sv
// Self-checking testbench of load_budget_governor_top: it drives items and register writes
// with random idling and compares every result word with a predictor of the governor.
// Depends on lbg_pkg, the lbg interfaces and the governor RTL.
module load_budget_governor_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbg_pkg::*;

    localparam int unsigned       SMOOTH_GAIN = 6554;
    localparam int unsigned       PEAK_FALL   = 64881;
    localparam int unsigned       CFG_SLOTS   = 8;
    localparam int unsigned       PHASES      = 8;
    localparam int unsigned       PHASE_ITEMS = 200;
    localparam int unsigned       DIRECTED    = 25;
    localparam longint unsigned   UNIT_Q16    = 65536;

    typedef struct packed {
        logic [BUD_W-1:0]  budget;
        logic [LOAD_W-1:0] smoothed;
        logic [LOAD_W-1:0] peak;
        logic [CNT_W-1:0]  pressure;
        logic              accepted;
    } t_budget_outcome;

    class budget_scoreboard;
        t_cfg              regs;
        logic [BUD_W-1:0]  budget;
        logic [LOAD_W-1:0] smooth;
        logic [LOAD_W-1:0] peak;
        logic [WARM_W-1:0] warm_left;
        logic [CNT_W-1:0]  pressure;
        t_budget_outcome   due_q[$];
        int unsigned       fail_count;
        int unsigned       shown;

        function new();
            regs       = CFG_RESET;
            budget     = CFG_RESET.ceiling_units;
            smooth     = '0;
            peak       = '0;
            warm_left  = CFG_RESET.warmup_blocks;
            pressure   = '0;
            fail_count = 0;
            shown      = 0;
        endfunction

        function void note_fail(string msg);
            fail_count++;
            if (shown < 10) begin
                shown++;
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want != got)
                note_fail($sformatf("%s expected %0d, got %0d", name, want, got));
        endfunction

        function void apply_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                CFG_CEILING: regs.ceiling_units = value;
                CFG_FLOOR:   regs.floor_units   = value;
                CFG_TARGET:  regs.target_load   = value[TGT_W-1:0];
                CFG_ATTACK:  regs.attack_rate   = value[RATE_W-1:0];
                CFG_RELEASE: regs.release_rate  = value[RATE_W-1:0];
                CFG_BAND:    regs.dead_band     = value[TGT_W-1:0];
                CFG_WARMUP:  regs.warmup_blocks = value[WARM_W-1:0];
                CFG_LOOP:    regs.loop_enabled  = value[0];
                default:     return;
            endcase
            if (regs.ceiling_units == 0)
                regs.ceiling_units = CEILING_DEFAULT;
            if (regs.floor_units > regs.ceiling_units)
                regs.floor_units = regs.ceiling_units;
            if (regs.target_load < TARGET_MIN)
                regs.target_load = TARGET_MIN;
            else if (regs.target_load > TARGET_MAX)
                regs.target_load = TARGET_MAX;
            if (regs.attack_rate < ATTACK_MIN)
                regs.attack_rate = ATTACK_MIN;
            else if (regs.attack_rate > ATTACK_MAX)
                regs.attack_rate = ATTACK_MAX;
            if (regs.release_rate > RELEASE_MAX)
                regs.release_rate = RELEASE_MAX;
            if (regs.dead_band < BAND_MIN)
                regs.dead_band = BAND_MIN;
            else if (regs.dead_band > BAND_MAX)
                regs.dead_band = BAND_MAX;
            if (budget < regs.floor_units)
                budget = regs.floor_units;
            else if (budget > regs.ceiling_units)
                budget = regs.ceiling_units;
        endfunction

        function void note_item(logic [TIME_W-1:0] e, logic [TIME_W-1:0] d,
                                logic [BUD_W-1:0] u);
            logic [63:0]       ratio;
            logic [63:0]       lw;
            logic [63:0]       sw;
            logic [63:0]       pw;
            logic [63:0]       bw;
            logic [63:0]       uw;
            logic [63:0]       tw;
            logic [63:0]       rw;
            logic [63:0]       stepped;
            logic [63:0]       afford;
            logic [LOAD_W-1:0] load;
            bit                ok;
            t_budget_outcome   want;

            ok   = 1'b0;
            load = '0;
            if (d != 0) begin
                ratio = {16'b0, e, 16'b0} / {32'b0, d};
                ok    = (ratio <= LOAD_LIMIT);
                load  = ratio[LOAD_W-1:0];
            end

            if (ok) begin
                lw = load;
                sw = smooth;
                if (lw >= sw) begin
                    stepped = ((lw - sw) * SMOOTH_GAIN + 32768) >> 16;
                    smooth  = smooth + stepped[LOAD_W-1:0];
                end else begin
                    stepped = ((sw - lw) * SMOOTH_GAIN + 32768) >> 16;
                    smooth  = smooth - stepped[LOAD_W-1:0];
                end

                if (load > peak) begin
                    peak = load;
                end else begin
                    pw   = peak;
                    pw   = (pw * PEAK_FALL) >> 16;
                    peak = pw[LOAD_W-1:0];
                end

                if (load > regs.target_load && pressure != '1)
                    pressure++;

                if (regs.loop_enabled) begin
                    bw = budget;
                    tw = regs.target_load;
                    if (warm_left != 0) begin
                        warm_left--;
                        budget = regs.ceiling_units;
                    end else if (load > regs.target_load) begin
                        stepped = (bw * (UNIT_Q16 - regs.attack_rate)) >> 16;
                        if (load >= LOAD_ONE && u != 0) begin
                            uw     = u;
                            afford = (uw * tw) / lw;
                            if (afford < stepped)
                                stepped = afford;
                        end
                        budget = (stepped < regs.floor_units) ? regs.floor_units
                                                              : stepped[BUD_W-1:0];
                    end else if ((lw << 16) < tw * regs.dead_band) begin
                        rw      = regs.release_rate;
                        stepped = (bw * (UNIT_Q16 + rw) + rw * 4096) >> 16;
                        budget  = (stepped > regs.ceiling_units) ? regs.ceiling_units
                                                                 : stepped[BUD_W-1:0];
                    end
                end
            end

            want.budget   = budget;
            want.smoothed = smooth;
            want.peak     = peak;
            want.pressure = pressure;
            want.accepted = ok;
            due_q.push_back(want);
        endfunction

        function void check_result(t_budget_outcome got);
            t_budget_outcome want;
            if (due_q.size() == 0) begin
                note_fail($sformatf({"result word with nothing expected: budget %0d ",
                                     "smoothed %0d peak %0d pressure %0d accepted %0b"},
                                    got.budget, got.smoothed, got.peak, got.pressure,
                                    got.accepted));
                return;
            end
            want = due_q.pop_front();
            compare_field("budget_units", want.budget, got.budget);
            compare_field("smoothed_load_out", want.smoothed, got.smoothed);
            compare_field("peak_load_out", want.peak, got.peak);
            compare_field("pressure_count", want.pressure, got.pressure);
            compare_field("sample_accepted", want.accepted, got.accepted);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   steady;

    lbg_item_if   item_bus ();
    lbg_result_if res_bus ();
    lbg_cfg_if    cfg_bus ();

    budget_scoreboard sb;

    load_budget_governor_top #(
        .LOAD_SMOOTHING (SMOOTH_GAIN),
        .PEAK_DECAY     (PEAK_FALL),
        .TIME_BITS      (TIME_W)
    ) dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_bus),
        .o_result (res_bus),
        .i_cfg    (cfg_bus)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int unsigned pick_pause();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 4);
        else if (roll < 98)
            return $urandom_range(5, 20);
        else
            return $urandom_range(40, 150);
    endfunction

    task automatic put_item(input logic [TIME_W-1:0] e, input logic [TIME_W-1:0] d,
                            input logic [BUD_W-1:0] u);
        int unsigned gap;
        item_bus.elapsed_ticks  = e;
        item_bus.deadline_ticks = d;
        item_bus.units_spent    = u;
        item_bus.valid          = 1'b1;
        do @(posedge clk); while (!item_bus.ready);
        sb.note_item(e, d, u);
        @(negedge clk);
        gap = pick_pause();
        if (gap != 0) begin
            item_bus.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        item_bus.valid = 1'b0;
        while (sb.due_q.size() != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [IDX_W-1:0] idx,
                                  input logic [DATA_W-1:0] value);
        cfg_bus.index = idx;
        cfg_bus.data  = value;
        cfg_bus.valid = 1'b1;
        do @(posedge clk); while (!cfg_bus.ready);
        sb.apply_write(idx, value);
        @(negedge clk);
        cfg_bus.valid = 1'b0;
    endtask

    initial begin : result_sink
        int unsigned     hold;
        t_budget_outcome got;
        hold = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && res_bus.valid && res_bus.ready) begin
                got.budget   = res_bus.budget_units;
                got.smoothed = res_bus.smoothed_load_out;
                got.peak     = res_bus.peak_load_out;
                got.pressure = res_bus.pressure_count;
                got.accepted = res_bus.sample_accepted;
                sb.check_result(got);
            end
            @(negedge clk);
            if (hold != 0) begin
                res_bus.ready = 1'b0;
                hold--;
            end else begin
                res_bus.ready = 1'b1;
                hold = pick_pause();
            end
        end
    end

    initial begin : stimulus
        logic [TIME_W-1:0] dir_e[DIRECTED];
        logic [TIME_W-1:0] dir_d[DIRECTED];
        logic [BUD_W-1:0]  dir_u[DIRECTED];
        logic [TIME_W-1:0] e_val;
        logic [TIME_W-1:0] d_val;
        logic [BUD_W-1:0]  u_val;
        logic [IDX_W-1:0]  slot;
        logic [DATA_W-1:0] value;
        longint unsigned   span;
        int unsigned       k;
        int unsigned       lo;
        int unsigned       hi;
        int unsigned       rot;
        int unsigned       roll;

        sb = new();
        steady = 1'b0;
        rst_n = 1'b0;
        item_bus.valid          = 1'b0;
        item_bus.elapsed_ticks  = '0;
        item_bus.deadline_ticks = '0;
        item_bus.units_spent    = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = '0;
        cfg_bus.data  = '0;

        dir_e = '{32'd0, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd64, 32'd65, 32'd6400001,
                  32'd64001, 32'hFFFF_FFFF, 32'd1, 32'h7FFF_FFFF,
                  32'd3, 32'd3, 32'd3, 32'd3, 32'd3, 32'd3, 32'd3, 32'd3, 32'd3, 32'd3,
                  32'd2, 32'd5, 32'd1, 32'd3};
        dir_d = '{32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd100000,
                  32'd1000, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000,
                  32'd4, 32'd4, 32'd4, 32'd4, 32'd4, 32'd4, 32'd4, 32'd4, 32'd4, 32'd4,
                  32'd1, 32'd4, 32'd1000, 32'd1};
        dir_u = '{24'd0, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd1, 24'd1, 24'd5,
                  24'd5, 24'd0, 24'hFFFFFF, 24'd0,
                  24'h1000, 24'h1000, 24'h1000, 24'h1000, 24'h1000,
                  24'h1000, 24'h1000, 24'h1000, 24'h1000, 24'h1000,
                  24'h1000, 24'd0, 24'd0, 24'hFFFFFF};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Zero deadlines, loads on both sides of 64.0, then the end of warm-up
        // followed by overload with and without an affordable budget and underload.
        for (int i = 0; i < DIRECTED; i++)
            put_item(dir_e[i], dir_d[i], dir_u[i]);

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            steady = (p == 3);
            write_register(IDX_W'($urandom_range(CFG_SLOTS, 255)), DATA_W'($urandom));
            rot = $urandom_range(0, CFG_SLOTS - 1);
            for (int n = 0; n < CFG_SLOTS; n++) begin
                slot = IDX_W'((n + rot) % CFG_SLOTS);
                case (slot)
                    CFG_CEILING: begin lo = 1;    hi = 24'hFFFFFF; end
                    CFG_FLOOR:   begin lo = 0;    hi = 24'h00FFFF; end
                    CFG_TARGET:  begin lo = 3277; hi = 65536;      end
                    CFG_ATTACK:  begin lo = 66;   hi = 58982;      end
                    CFG_RELEASE: begin lo = 0;    hi = 58982;      end
                    CFG_BAND:    begin lo = 6554; hi = 65536;      end
                    CFG_WARMUP:  begin lo = 0;    hi = 65535;      end
                    default:     begin lo = 0;    hi = 1;          end
                endcase
                roll = $urandom_range(0, 4);
                if (p == 0)
                    value = '0;
                else if (p == 1)
                    value = '1;
                else if (slot == CFG_LOOP)
                    value = DATA_W'($urandom_range(0, 3) != 0);
                else if (roll < 2)
                    value = DATA_W'($urandom_range(lo, hi));
                else if (roll == 2)
                    value = DATA_W'(lo);
                else if (roll == 3)
                    value = DATA_W'(hi);
                else
                    value = DATA_W'($urandom);
                write_register(slot, value);
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 4) begin
                    e_val = $urandom;
                    d_val = '0;
                end else if (roll < 8) begin
                    e_val = $urandom;
                    d_val = $urandom;
                end else if (roll < 12) begin
                    d_val = $urandom_range(1, 24'hFFFFFF);
                    e_val = (d_val << 6) + $urandom_range(0, 2);
                end else if (roll < 16) begin
                    d_val = $urandom_range(1, 65535);
                    e_val = d_val * $urandom_range(65, 65000) + $urandom_range(0, 3);
                end else begin
                    d_val = $urandom >> $urandom_range(0, 24);
                    if (d_val == 0)
                        d_val = 1;
                    roll = $urandom_range(0, 2);
                    if (roll == 0)
                        k = $urandom_range(0, 3 * 65536);
                    else if (roll == 1)
                        k = sb.regs.target_load + $urandom_range(0, 2000) - 1000;
                    else
                        k = ((sb.regs.target_load * sb.regs.dead_band) >> 16)
                            + $urandom_range(0, 4) - 2;
                    span = (longint'(d_val) * k) >> 16;
                    e_val = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[TIME_W-1:0];
                end
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    u_val = '0;
                else if (roll == 1)
                    u_val = '1;
                else
                    u_val = BUD_W'($urandom);
                put_item(e_val, d_val, u_val);
                if ($urandom_range(0, 99) == 0)
                    drain_results();
            end
        end

        steady = 1'b0;
        drain_results();
        repeat (80) @(posedge clk);
        if (sb.fail_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
